/* rtl/pcode_stack_machine_core_defines.svh */
// assertion macros shared by the rtl files of the p-code stack machine
// no dependencies; included by files that carry concurrent checks
`ifndef PCODE_STACK_MACHINE_CORE_DEFINES_SVH
`define PCODE_STACK_MACHINE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define PCSM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property on every clock edge, reset included
`define PCSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCSM_ASSERT(lbl, clk, rst, prop, msg)
`define PCSM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/pcsm_pkg.sv */
// shared constants, codes and helpers of the p-code stack machine
// no dependencies; imported by every module of the block
package pcsm_pkg;

   localparam int STACK_DEPTH_DEF = 512;
   localparam int MAX_LEVEL       = 3;
   localparam int DATA_WIDTH      = 32;
   localparam int PC_W            = 8;
   // signed width wide enough for base plus operand without overflow
   localparam int IDX_W           = DATA_WIDTH + 2;

   localparam logic signed [IDX_W-1:0] IDX_ONE   = IDX_W'(1);
   localparam logic signed [IDX_W-1:0] IDX_TWO   = IDX_W'(2);
   localparam logic signed [IDX_W-1:0] IDX_THREE = IDX_W'(3);

   // instruction kinds
   localparam logic [2:0] F_LIT = 3'd0;
   localparam logic [2:0] F_OPR = 3'd1;
   localparam logic [2:0] F_LOD = 3'd2;
   localparam logic [2:0] F_STO = 3'd3;
   localparam logic [2:0] F_CAL = 3'd4;
   localparam logic [2:0] F_INT = 3'd5;
   localparam logic [2:0] F_JMP = 3'd6;
   localparam logic [2:0] F_JPC = 3'd7;

   // operation numbers
   localparam logic [DATA_WIDTH-1:0] OPR_RET = DATA_WIDTH'(0);
   localparam logic [DATA_WIDTH-1:0] OPR_NEG = DATA_WIDTH'(1);
   localparam logic [DATA_WIDTH-1:0] OPR_ADD = DATA_WIDTH'(2);
   localparam logic [DATA_WIDTH-1:0] OPR_SUB = DATA_WIDTH'(3);
   localparam logic [DATA_WIDTH-1:0] OPR_MUL = DATA_WIDTH'(4);
   localparam logic [DATA_WIDTH-1:0] OPR_DIV = DATA_WIDTH'(5);
   localparam logic [DATA_WIDTH-1:0] OPR_ODD = DATA_WIDTH'(6);
   localparam logic [DATA_WIDTH-1:0] OPR_EQ  = DATA_WIDTH'(8);
   localparam logic [DATA_WIDTH-1:0] OPR_NE  = DATA_WIDTH'(9);
   localparam logic [DATA_WIDTH-1:0] OPR_LT  = DATA_WIDTH'(10);
   localparam logic [DATA_WIDTH-1:0] OPR_GE  = DATA_WIDTH'(11);
   localparam logic [DATA_WIDTH-1:0] OPR_GT  = DATA_WIDTH'(12);
   localparam logic [DATA_WIDTH-1:0] OPR_LE  = DATA_WIDTH'(13);

   // fault codes
   localparam logic [1:0] FLT_NONE  = 2'd0;
   localparam logic [1:0] FLT_DIV0  = 2'd1;
   localparam logic [1:0] FLT_RANGE = 2'd2;
   localparam logic [1:0] FLT_OPR   = 2'd3;

   typedef logic signed [IDX_W-1:0] idx_type;

   // true when a signed index falls inside a stack of the given depth
   function automatic logic in_range(idx_type v, int depth);
      logic [IDX_W-2:0] mag;
      mag = v[IDX_W-2:0];
      return !v[IDX_W-1] && (mag < (IDX_W-1)'(depth));
   endfunction

   // sign extension of a data word to index width
   function automatic idx_type sext_data(logic [DATA_WIDTH-1:0] v);
      return $signed({{(IDX_W-DATA_WIDTH){v[DATA_WIDTH-1]}}, v});
   endfunction

endpackage

/* rtl/pcsm_stack_mem.sv */
// data stack storage: one write port, one registered read port
// depends on pcsm_pkg for the data width
module pcsm_stack_mem
   import pcsm_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   localparam int AW = $clog2(STACK_DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [AW-1:0]         rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/pcsm_divider.sv */
// signed truncating divider, one quotient bit per cycle
// depends on pcsm_pkg for the data width
module pcsm_divider
   import pcsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] quotient
);

   localparam int CW = $clog2(DATA_WIDTH + 1);

   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] dvs_ff, dvs_in;
   logic                  neg_ff, neg_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DATA_WIDTH:0]   rem_sh;
   logic [DATA_WIDTH:0]   rem_sub;

   // one restoring step per cycle on magnitudes
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, quo_ff[DATA_WIDTH-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
         dvs_in  = divisor[DATA_WIDTH-1] ? (~divisor + 1'b1) : divisor;
         neg_in  = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
         cnt_in  = CW'(DATA_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!rem_sub[DATA_WIDTH]) begin
            rem_in = rem_sub[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   // sign fix of the magnitude quotient
   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

/* rtl/pcode_stack_machine_core.sv */
// p-code stack machine: one instruction per req item, one rsp item back.
// req carries func, level and operand; the item is taken when req_valid is
// high and req_stall low. rsp carries next_pc, top_value, halted and fault
// and is held in an output register until rsp_stall is low.
// Each item runs from decode through its own steps to a commit step and
// an output step, where the result register is loaded; the next item is
// taken in the idle state that follows. Each static link takes a read
// issue and a capture step on the single read port of the stack memory;
// the divider retires one bit per cycle.
// Only one instruction is in flight; a new item is accepted while the
// previous result still waits in the output register, and the sequencer
// waits at its last step if that register is still full.
// After reset the stack is cleared by a pass over every entry,
// one entry per cycle, during which req_stall stays high.
// Pointers reset to top 0, frame base 1 and counter 0. Any fault leaves
// the state untouched.
// depends on pcsm_pkg, pcsm_stack_mem, pcsm_divider and the defines header
`include "pcode_stack_machine_core_defines.svh"
module pcode_stack_machine_core
   import pcsm_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_func,
   input  logic [1:0]                   req_level,
   input  logic signed [DATA_WIDTH-1:0] req_operand,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [PC_W-1:0]              rsp_next_pc,
   output logic signed [DATA_WIDTH-1:0] rsp_top_value,
   output logic                         rsp_halted,
   output logic [1:0]                   rsp_fault
);

   localparam int AW = $clog2(STACK_DEPTH);

   localparam logic [4:0] S_CLEAR   = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_DECODE  = 5'd2;
   localparam logic [4:0] S_WALK    = 5'd3;
   localparam logic [4:0] S_WALK_WT = 5'd4;
   localparam logic [4:0] S_LINKED  = 5'd5;
   localparam logic [4:0] S_LOD_WR  = 5'd6;
   localparam logic [4:0] S_STO_WR  = 5'd7;
   localparam logic [4:0] S_CAL2    = 5'd8;
   localparam logic [4:0] S_CAL3    = 5'd9;
   localparam logic [4:0] S_RET1    = 5'd10;
   localparam logic [4:0] S_RET2    = 5'd11;
   localparam logic [4:0] S_UNARY   = 5'd12;
   localparam logic [4:0] S_BIN_X   = 5'd13;
   localparam logic [4:0] S_BIN_Y   = 5'd14;
   localparam logic [4:0] S_DIV     = 5'd15;
   localparam logic [4:0] S_BIN_WR  = 5'd16;
   localparam logic [4:0] S_JPC     = 5'd17;
   localparam logic [4:0] S_FIN     = 5'd18;
   localparam logic [4:0] S_OUT     = 5'd19;

   logic [4:0]            state_ff, state_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [AW-1:0]         top_ff, top_in;
   logic [AW-1:0]         base_ff, base_in;
   logic [PC_W-1:0]       pc_ff, pc_in;
   logic [2:0]            func_ff, func_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] opnd_ff, opnd_in;
   logic [DATA_WIDTH-1:0] link_ff, link_in;
   logic [DATA_WIDTH-1:0] xval_ff, xval_in;
   logic [DATA_WIDTH-1:0] res_ff, res_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic [AW-1:0]         tnew_ff, tnew_in;
   logic [AW-1:0]         nbnew_ff, nbnew_in;
   logic [PC_W-1:0]       npnew_ff, npnew_in;
   logic [1:0]            fault_ff, fault_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PC_W-1:0]       rsp_pc_ff, rsp_pc_in;
   logic [DATA_WIDTH-1:0] rsp_top_ff, rsp_top_in;
   logic                  rsp_halt_ff, rsp_halt_in;
   logic [1:0]            rsp_fault_ff, rsp_fault_in;

   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [DATA_WIDTH-1:0] mem_wdata;
   logic [AW-1:0]         mem_raddr;
   logic [DATA_WIDTH-1:0] mem_rdata;
   logic                  div_start;
   logic                  div_done;
   logic [DATA_WIDTH-1:0] div_quo;

   idx_type top_x, base_x, op_x, link_x;
   idx_type top_p1, top_p3, top_m1, top_op, base_m1, base_p1, base_p2, link_op;
   logic [1:0] lev_sat;

   pcsm_stack_mem #(.STACK_DEPTH(STACK_DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   pcsm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (xval_ff),
      .divisor  (mem_rdata),
      .done     (div_done),
      .quotient (div_quo)
   );

   // index arithmetic for range checks
   assign top_x   = $signed({{(IDX_W-AW){1'b0}}, top_ff});
   assign base_x  = $signed({{(IDX_W-AW){1'b0}}, base_ff});
   assign op_x    = sext_data(opnd_ff);
   assign link_x  = sext_data(link_ff);
   assign top_p1  = top_x + IDX_ONE;
   assign top_p3  = top_x + IDX_THREE;
   assign top_m1  = top_x - IDX_ONE;
   assign top_op  = top_x + op_x;
   assign base_m1 = base_x - IDX_ONE;
   assign base_p1 = base_x + IDX_ONE;
   assign base_p2 = base_x + IDX_TWO;
   assign link_op = link_x + op_x;
   assign lev_sat = (int'(req_level) > MAX_LEVEL) ? 2'(MAX_LEVEL) : req_level;

   // sequencer: reads, modifies and writes the stack one access per cycle
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      top_in       = top_ff;
      base_in      = base_ff;
      pc_in        = pc_ff;
      func_in      = func_ff;
      cnt_in       = cnt_ff;
      opnd_in      = opnd_ff;
      link_in      = link_ff;
      xval_in      = xval_ff;
      res_in       = res_ff;
      addr_in      = addr_ff;
      tnew_in      = tnew_ff;
      nbnew_in     = nbnew_ff;
      npnew_in     = npnew_ff;
      fault_in     = fault_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pc_in    = rsp_pc_ff;
      rsp_top_in   = rsp_top_ff;
      rsp_halt_in  = rsp_halt_ff;
      rsp_fault_in = rsp_fault_ff;
      mem_we       = 1'b0;
      mem_waddr    = top_ff;
      mem_wdata    = '0;
      mem_raddr    = top_ff;
      div_start    = 1'b0;

      // output register drains independently of the sequencer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(STACK_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               cnt_in   = lev_sat;
               opnd_in  = req_operand;
               link_in  = DATA_WIDTH'(base_ff);
               tnew_in  = top_ff;
               nbnew_in = base_ff;
               npnew_in = pc_ff + 1'b1;
               fault_in = FLT_NONE;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_FIN;
            unique case (func_ff)
               F_LIT: begin
                  if (!in_range(top_p1, STACK_DEPTH)) begin
                     fault_in = FLT_RANGE;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = top_p1[AW-1:0];
                     mem_wdata = opnd_ff;
                     tnew_in   = top_p1[AW-1:0];
                  end
               end
               F_OPR: begin
                  priority if (opnd_ff == OPR_RET) begin
                     if (!in_range(base_m1, STACK_DEPTH) ||
                         !in_range(base_p2, STACK_DEPTH)) begin
                        fault_in = FLT_RANGE;
                     end else begin
                        mem_raddr = base_p1[AW-1:0];
                        state_in  = S_RET1;
                     end
                  end else if (opnd_ff == OPR_NEG || opnd_ff == OPR_ODD) begin
                     state_in = S_UNARY;
                  end else if (opnd_ff == OPR_ADD || opnd_ff == OPR_SUB ||
                               opnd_ff == OPR_MUL || opnd_ff == OPR_DIV ||
                               opnd_ff == OPR_EQ || opnd_ff == OPR_NE ||
                               opnd_ff == OPR_LT || opnd_ff == OPR_GE ||
                               opnd_ff == OPR_GT || opnd_ff == OPR_LE) begin
                     if (!in_range(top_m1, STACK_DEPTH)) begin
                        fault_in = FLT_RANGE;
                     end else begin
                        mem_raddr = top_m1[AW-1:0];
                        state_in  = S_BIN_X;
                     end
                  end else begin
                     fault_in = FLT_OPR;
                  end
               end
               F_LOD, F_STO, F_CAL: begin
                  state_in = S_WALK;
               end
               F_INT: begin
                  if (!in_range(top_op, STACK_DEPTH)) begin
                     fault_in = FLT_RANGE;
                  end else begin
                     tnew_in = top_op[AW-1:0];
                  end
               end
               F_JMP: begin
                  npnew_in = opnd_ff[PC_W-1:0];
               end
               F_JPC: begin
                  if (!in_range(top_m1, STACK_DEPTH)) begin
                     fault_in = FLT_RANGE;
                  end else begin
                     state_in = S_JPC;
                  end
               end
               default: begin
                  fault_in = FLT_OPR;
               end
            endcase
         end
         // static link walk: read issue, then capture, for each level
         S_WALK: begin
            if (!in_range(link_x, STACK_DEPTH)) begin
               fault_in = FLT_RANGE;
               state_in = S_FIN;
            end else if (cnt_ff == 2'd0) begin
               state_in = S_LINKED;
            end else begin
               mem_raddr = link_ff[AW-1:0];
               cnt_in    = cnt_ff - 1'b1;
               state_in  = S_WALK_WT;
            end
         end
         S_WALK_WT: begin
            link_in  = mem_rdata;
            state_in = S_WALK;
         end
         S_LINKED: begin
            state_in = S_FIN;
            priority case (func_ff)
               F_LOD: begin
                  if (!in_range(link_op, STACK_DEPTH) ||
                      !in_range(top_p1, STACK_DEPTH)) begin
                     fault_in = FLT_RANGE;
                  end else begin
                     mem_raddr = link_op[AW-1:0];
                     state_in  = S_LOD_WR;
                  end
               end
               F_STO: begin
                  if (!in_range(link_op, STACK_DEPTH) ||
                      !in_range(top_m1, STACK_DEPTH)) begin
                     fault_in = FLT_RANGE;
                  end else begin
                     addr_in  = link_op[AW-1:0];
                     state_in = S_STO_WR;
                  end
               end
               default: begin
                  if (!in_range(top_p3, STACK_DEPTH)) begin
                     fault_in = FLT_RANGE;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = top_p1[AW-1:0];
                     mem_wdata = link_ff;
                     state_in  = S_CAL2;
                  end
               end
            endcase
         end
         S_LOD_WR: begin
            mem_we    = 1'b1;
            mem_waddr = top_p1[AW-1:0];
            mem_wdata = mem_rdata;
            tnew_in   = top_p1[AW-1:0];
            state_in  = S_FIN;
         end
         S_STO_WR: begin
            mem_we    = 1'b1;
            mem_waddr = addr_ff;
            mem_wdata = mem_rdata;
            tnew_in   = top_m1[AW-1:0];
            state_in  = S_FIN;
         end
         // call frame: static link, dynamic link, return address
         S_CAL2: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(top_p1 + IDX_ONE);
            mem_wdata = DATA_WIDTH'(base_ff);
            state_in  = S_CAL3;
         end
         S_CAL3: begin
            mem_we    = 1'b1;
            mem_waddr = top_p3[AW-1:0];
            mem_wdata = DATA_WIDTH'(npnew_ff);
            nbnew_in  = top_p1[AW-1:0];
            npnew_in  = opnd_ff[PC_W-1:0];
            state_in  = S_FIN;
         end
         // return: fetch saved base, then return address
         S_RET1: begin
            link_in   = mem_rdata;
            mem_raddr = base_p2[AW-1:0];
            state_in  = S_RET2;
         end
         S_RET2: begin
            if (!in_range(link_x, STACK_DEPTH)) begin
               fault_in = FLT_RANGE;
            end else begin
               npnew_in = mem_rdata[PC_W-1:0];
               tnew_in  = base_m1[AW-1:0];
               nbnew_in = link_ff[AW-1:0];
            end
            state_in = S_FIN;
         end
         S_UNARY: begin
            mem_we   = 1'b1;
            if (opnd_ff == OPR_NEG) begin
               mem_wdata = ~mem_rdata + 1'b1;
            end else begin
               mem_wdata = {{(DATA_WIDTH-1){1'b0}}, mem_rdata[0]};
            end
            state_in = S_FIN;
         end
         S_BIN_X: begin
            xval_in  = mem_rdata;
            state_in = S_BIN_Y;
         end
         // second operand arrives; compute, fault on a zero divisor or launch the divider
         S_BIN_Y: begin
            state_in = S_BIN_WR;
            priority if (opnd_ff == OPR_ADD) begin
               res_in = xval_ff + mem_rdata;
            end else if (opnd_ff == OPR_SUB) begin
               res_in = xval_ff - mem_rdata;
            end else if (opnd_ff == OPR_MUL) begin
               res_in = xval_ff * mem_rdata;
            end else if (opnd_ff == OPR_DIV) begin
               priority if (mem_rdata == '0) begin
                  fault_in = FLT_DIV0;
                  state_in = S_FIN;
               end else if (mem_rdata == '1) begin
                  res_in = ~xval_ff + 1'b1;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end else if (opnd_ff == OPR_EQ) begin
               res_in = DATA_WIDTH'(xval_ff == mem_rdata);
            end else if (opnd_ff == OPR_NE) begin
               res_in = DATA_WIDTH'(xval_ff != mem_rdata);
            end else if (opnd_ff == OPR_LT) begin
               res_in = DATA_WIDTH'($signed(xval_ff) < $signed(mem_rdata));
            end else if (opnd_ff == OPR_GE) begin
               res_in = DATA_WIDTH'($signed(xval_ff) >= $signed(mem_rdata));
            end else if (opnd_ff == OPR_GT) begin
               res_in = DATA_WIDTH'($signed(xval_ff) > $signed(mem_rdata));
            end else begin
               res_in = DATA_WIDTH'($signed(xval_ff) <= $signed(mem_rdata));
            end
         end
         S_DIV: begin
            if (div_done) begin
               res_in   = div_quo;
               state_in = S_BIN_WR;
            end
         end
         S_BIN_WR: begin
            mem_we    = 1'b1;
            mem_waddr = top_m1[AW-1:0];
            mem_wdata = res_ff;
            tnew_in   = top_m1[AW-1:0];
            state_in  = S_FIN;
         end
         S_JPC: begin
            if (mem_rdata == '0) begin
               npnew_in = opnd_ff[PC_W-1:0];
            end
            tnew_in  = top_m1[AW-1:0];
            state_in = S_FIN;
         end
         // commit pointers unless faulted and fetch the new top
         S_FIN: begin
            if (fault_ff == FLT_NONE) begin
               top_in    = tnew_ff;
               base_in   = nbnew_ff;
               pc_in     = npnew_ff;
               mem_raddr = tnew_ff;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_pc_in    = pc_ff;
               rsp_top_in   = mem_rdata;
               rsp_halt_in  = (fault_ff == FLT_NONE) && (pc_ff == '0);
               rsp_fault_in = fault_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         top_ff       <= '0;
         base_ff      <= AW'(1);
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         fault_ff     <= FLT_NONE;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         top_ff       <= top_in;
         base_ff      <= base_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         fault_ff     <= fault_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      cnt_ff       <= cnt_in;
      opnd_ff      <= opnd_in;
      link_ff      <= link_in;
      xval_ff      <= xval_in;
      res_ff       <= res_in;
      addr_ff      <= addr_in;
      tnew_ff      <= tnew_in;
      nbnew_ff     <= nbnew_in;
      npnew_ff     <= npnew_in;
      rsp_pc_ff    <= rsp_pc_in;
      rsp_top_ff   <= rsp_top_in;
      rsp_halt_ff  <= rsp_halt_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_next_pc   = rsp_pc_ff;
   assign rsp_top_value = $signed(rsp_top_ff);
   assign rsp_halted    = rsp_halt_ff;
   assign rsp_fault     = rsp_fault_ff;

   // checks
   `PCSM_ASSERT(a_one_in_flight, clock, reset, (req_valid && !req_stall) |=> req_stall, "item accepted while busy")
   `PCSM_ASSERT(a_no_write_on_fault, clock, reset, (mem_we && state_ff != S_CLEAR) |-> (fault_ff == FLT_NONE), "stack written during a faulting item")
   `PCSM_ASSERT(a_halt_clean, clock, reset, rsp_valid |-> !(rsp_halted && rsp_fault != FLT_NONE), "halt reported with a fault")
   `PCSM_ASSERT(a_top_in_range, clock, reset, int'(top_ff) < STACK_DEPTH, "stack top outside the stack")

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// testbench for the p-code stack machine core: directed and random programs
// checked against an in-bench model of the machine; depends on pcsm_pkg and the core
module tb;
   import pcsm_pkg::*;

   localparam int DEPTH = STACK_DEPTH_DEF;
   localparam int CODE = 256;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [2:0] req_func;
   logic [1:0] req_level;
   logic signed [DATA_WIDTH-1:0] req_operand;
   logic rsp_valid, rsp_stall;
   logic [PC_W-1:0] rsp_next_pc;
   logic signed [DATA_WIDTH-1:0] rsp_top_value;
   logic rsp_halted;
   logic [1:0] rsp_fault;

   pcode_stack_machine_core DUT (.*);

   typedef struct packed {
      logic [PC_W-1:0] pc;
      logic [DATA_WIDTH-1:0] top;
      logic halted;
      logic [1:0] fault;
   } step_result_type;

   // machine model state
   logic [DATA_WIDTH-1:0] mem [DEPTH];
   longint top_idx, base_idx;
   logic [PC_W-1:0] pc;

   step_result_type pending_results[$];
   int n_errors;
   int hold_off_cycles;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // end of run after a generous fixed time
   initial begin
      #200ms;
      $display("tb: done, errors");
      $finish;
   end

   function automatic longint sx(logic [DATA_WIDTH-1:0] v);
      return longint'($signed(v));
   endfunction

   function automatic bit ok(longint i);
      return i >= 0 && i < DEPTH;
   endfunction

   // static link walk, -1 when out of range
   function automatic longint link_base(int lev);
      longint b;
      b = base_idx;
      repeat (lev) begin
         if (!ok(b)) return -1;
         b = sx(mem[b]);
      end
      return ok(b) ? b : -1;
   endfunction

   // execute one instruction on the model and queue the result
   function automatic void run_instruction(logic [2:0] f, logic [1:0] lev,
                                           logic [DATA_WIDTH-1:0] op);
      longint t, nb, bs, opi, idx;
      logic [PC_W-1:0] np, tgt;
      logic [1:0] flt;
      logic [DATA_WIDTH-1:0] x, y, r;
      step_result_type res;
      t = top_idx; nb = base_idx; opi = sx(op);
      tgt = op[PC_W-1:0]; np = pc + 1'b1; flt = FLT_NONE;
      case (f)
         F_LIT: begin
            if (!ok(t + 1)) flt = FLT_RANGE;
            else begin t++; mem[t] = op; end
         end
         F_OPR: begin
            if (op == OPR_RET) begin
               if (!ok(nb - 1) || !ok(nb + 2)) flt = FLT_RANGE;
               else begin
                  bs = sx(mem[nb + 1]);
                  if (!ok(bs)) flt = FLT_RANGE;
                  else begin
                     np = mem[nb + 2][PC_W-1:0];
                     t = nb - 1; nb = bs;
                  end
               end
            end else if (op == OPR_NEG) mem[t] = -mem[t];
            else if (op == OPR_ODD) mem[t] = mem[t] & 1;
            else if ((opi >= 2 && opi <= 5) || (opi >= 8 && opi <= 13)) begin
               if (!ok(t - 1)) flt = FLT_RANGE;
               else begin
                  x = mem[t - 1]; y = mem[t]; r = '0;
                  case (op)
                     OPR_ADD: r = x + y;
                     OPR_SUB: r = x - y;
                     OPR_MUL: r = x * y;
                     OPR_DIV: begin
                        if (y == 0) flt = FLT_DIV0;
                        else r = DATA_WIDTH'(sx(x) / sx(y));
                     end
                     OPR_EQ: r = DATA_WIDTH'(x == y);
                     OPR_NE: r = DATA_WIDTH'(x != y);
                     OPR_LT: r = DATA_WIDTH'(sx(x) < sx(y));
                     OPR_GE: r = DATA_WIDTH'(sx(x) >= sx(y));
                     OPR_GT: r = DATA_WIDTH'(sx(x) > sx(y));
                     default: r = DATA_WIDTH'(sx(x) <= sx(y));
                  endcase
                  if (flt == FLT_NONE) begin t--; mem[t] = r; end
               end
            end else flt = FLT_OPR;
         end
         F_LOD, F_STO, F_CAL: begin
            bs = link_base(lev);
            if (bs < 0) flt = FLT_RANGE;
            else if (f == F_LOD) begin
               idx = bs + opi;
               if (!ok(idx) || !ok(t + 1)) flt = FLT_RANGE;
               else begin t++; mem[t] = mem[idx]; end
            end else if (f == F_STO) begin
               idx = bs + opi;
               if (!ok(idx) || !ok(t - 1)) flt = FLT_RANGE;
               else begin mem[idx] = mem[t]; t--; end
            end else begin
               if (!ok(t + 3)) flt = FLT_RANGE;
               else begin
                  mem[t + 1] = DATA_WIDTH'(bs);
                  mem[t + 2] = DATA_WIDTH'(nb);
                  mem[t + 3] = DATA_WIDTH'(np);
                  nb = t + 1; np = tgt;
               end
            end
         end
         F_INT: begin
            if (!ok(t + opi)) flt = FLT_RANGE;
            else t += opi;
         end
         F_JMP: np = tgt;
         default: begin
            if (!ok(t - 1)) flt = FLT_RANGE;
            else begin
               if (mem[t] == 0) np = tgt;
               t--;
            end
         end
      endcase
      if (flt == FLT_NONE) begin
         top_idx = t; base_idx = nb; pc = np;
      end
      res.pc = pc;
      res.top = mem[top_idx];
      res.halted = (flt == FLT_NONE) && (pc == 0);
      res.fault = flt;
      pending_results.push_back(res);
   endfunction

   // send one item, with a random gap first; valid stays up when there is none
   task automatic send_item(logic [2:0] f, logic [1:0] lev, logic [DATA_WIDTH-1:0] op);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f; req_level <= lev; req_operand <= op;
      do @(posedge clock); while (req_stall);
      run_instruction(f, lev, op);
   endtask

   // receiver stall pattern, with a long hold-off on request
   initial begin
      int gap;
      rsp_stall = 1'b1;
      hold_off_cycles = 0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles--;
         end else if (gap > 0) begin
            rsp_stall <= 1'b1;
            gap--;
         end else begin
            rsp_stall <= 1'b0;
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5);
         end
      end
   end

   // result checking
   always @(posedge clock) begin
      step_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("tb: unexpected result pc=%0d", rsp_next_pc);
         end else begin
            want = pending_results.pop_front();
            if (rsp_next_pc !== want.pc || rsp_top_value !== want.top ||
                rsp_halted !== want.halted || rsp_fault !== want.fault) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("tb: mismatch exp pc=%0d top=%h h=%b f=%0d got pc=%0d top=%h h=%b f=%0d",
                           want.pc, want.top, want.halted, want.fault, rsp_next_pc,
                           rsp_top_value, rsp_halted, rsp_fault);
            end
         end
      end
   end

   function automatic logic [DATA_WIDTH-1:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'(0);
         default: return $urandom;
      endcase
   endfunction

   // directed: extremes, all operations, faults
   task automatic test_directed();
      int k;
      send_item(F_LIT, 2'd0, 32'h8000_0000);
      send_item(F_LIT, 2'd3, 32'hffff_ffff);
      send_item(F_OPR, 2'd0, OPR_DIV);      // most negative / -1
      send_item(F_LIT, 2'd0, 32'd0);
      send_item(F_OPR, 2'd0, OPR_DIV);      // divide by zero
      send_item(F_OPR, 2'd0, 32'd7);        // unknown operation
      send_item(F_OPR, 2'd0, 32'hffff_fff0);
      send_item(F_OPR, 2'd0, 32'd14);
      for (k = 1; k <= 13; k++) begin
         if (k == 7) continue;
         send_item(F_LIT, 2'd0, 32'h7fff_fffd);
         send_item(F_OPR, 2'd0, 32'(k));
      end
      send_item(F_INT, 2'd0, 32'h8000_0000);  // out of range
      send_item(F_INT, 2'd0, 32'd507);
      send_item(F_LIT, 2'd0, 32'd5);          // overflow at the top
      send_item(F_INT, 2'd0, -32'sd508);
      send_item(F_JPC, 2'd0, 32'd300);
      send_item(F_JMP, 2'd0, 32'hffff_ff00);  // back to zero: halt
      send_item(F_LOD, 2'd3, 32'd1);
      send_item(F_STO, 2'd2, 32'h7fff_ffff);
      send_item(F_CAL, 2'd1, 32'd40);
      send_item(F_OPR, 2'd0, OPR_RET);
   endtask

   // random programs: all instruction kinds, mostly small operands for OPR, LOD, STO and INT
   task automatic test_random(int n);
      logic [2:0] f;
      logic [DATA_WIDTH-1:0] op;
      repeat (n) begin
         f = 3'($urandom_range(0, 7));
         case (f)
            F_OPR: op = $urandom_range(0, 9) == 0 ? rand_word() : $urandom_range(0, 14);
            F_LOD, F_STO: op = $urandom_range(0, 9) == 0 ? rand_word() : $urandom_range(0, 6);
            F_INT: op = $urandom_range(0, 9) == 0 ? rand_word() : $urandom_range(0, 4) - 1;
            default: op = rand_word();
         endcase
         send_item(f, 2'($urandom_range(0, 3)), op);
      end
   endtask

   // long receiver hold-off while items keep coming
   task automatic test_backpressure();
      hold_off_cycles = 300;
      test_random(30);
   endtask

   initial begin
      int waited;
      n_errors = 0;
      for (int i = 0; i < DEPTH; i++) mem[i] = '0;
      top_idx = 0; base_idx = 1; pc = '0;
      reset <= 1'b1;
      req_valid <= 1'b0; req_func <= F_LIT; req_level <= '0; req_operand <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random(590);
      req_valid <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (60) @(posedge clock);
      if (n_errors == 0 && pending_results.size() == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end
endmodule

/* files.f */
+incdir+rtl
rtl/pcsm_pkg.sv
rtl/pcsm_stack_mem.sv
rtl/pcsm_divider.sv
rtl/pcode_stack_machine_core.sv
verif/tb.sv
